[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on clk_i.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/kcsq_pkg.sv]
// ----------------------------------------------------------------------------
// kcsq_pkg
// Shared types and constants of the keyboard command / sound queue unit.
// ----------------------------------------------------------------------------
package kcsq_pkg;

  // Sound queue geometry
  localparam int unsigned QUEUE_DEPTH = 128;
  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W  = $clog2(2 * QUEUE_DEPTH);

  // Host command decode constants
  localparam logic [7:0] MODE_MASK = 8'h57;

  typedef logic [7:0] pending_t;

  typedef enum logic [1:0] {
    CMD_HOST = 2'd0,
    CMD_KEY  = 2'd1,
    CMD_POP  = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    SND_NONE  = 2'd0,
    SND_LONG  = 2'd1,
    SND_SHORT = 2'd2,
    SND_CLICK = 2'd3
  } snd_e;

  // Decoded effect of one item
  typedef struct packed {
    logic       host;
    logic [7:0] led;
    logic       mode_upd;
    logic       click;
    logic       rpt;
    logic       qwertz;
    logic       push;
    snd_e       sound;
    logic       pop;
  } dec_t;

  // Request to the sound queue
  typedef struct packed {
    logic       step;
    logic       push;
    logic       pop;
    snd_e       sound;
  } ring_req_t;

endpackage

[rtl/kcsq_if.sv]
// ----------------------------------------------------------------------------
// kcsq_if
// Valid/ready channels: command items in, status results out.
// ----------------------------------------------------------------------------
interface kcsq_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

interface kcsq_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  led_pattern;
  logic        click_on;
  logic        autorepeat_on;
  logic        qwertz_on;
  logic        popped_valid;
  logic [1:0]  popped_sound;
  logic [1:0]  latest_sound;
  logic [31:0] sound_total;
  logic [7:0]  pending_total;
  logic [7:0]  latest_command;
  logic [31:0] command_total;

  modport source (output valid, led_pattern, click_on, autorepeat_on, qwertz_on,
                  popped_valid, popped_sound, latest_sound, sound_total,
                  pending_total, latest_command, command_total,
                  input ready);
  modport sink   (input valid, led_pattern, click_on, autorepeat_on, qwertz_on,
                  popped_valid, popped_sound, latest_sound, sound_total,
                  pending_total, latest_command, command_total,
                  output ready);
endinterface

[rtl/kcsq_decode.sv]
// ----------------------------------------------------------------------------
// kcsq_decode
// Decodes one item: LED pattern, mode update, sound to queue, pop.
// ----------------------------------------------------------------------------
module kcsq_decode import kcsq_pkg::*; (
  input  logic [1:0] cmd_i,
  input  logic [7:0] value_i,
  input  logic       click_on_i,
  output dec_t       dec_o
);

  logic [7:0] led;

  // LED pattern from the low two bits
  always_comb begin
    case (value_i[1:0])
      2'b00:   led = value_i - 8'd2;
      2'b01:   led = value_i;
      default: led = value_i - 8'd1;
    endcase
  end

  always_comb begin
    dec_o          = '0;
    dec_o.sound    = SND_NONE;
    dec_o.led      = led;
    dec_o.mode_upd = (value_i & MODE_MASK) == MODE_MASK;
    dec_o.click    = ~value_i[3];
    dec_o.rpt      = ~value_i[5];
    dec_o.qwertz   = value_i[7];
    unique case (cmd_e'(cmd_i))
      CMD_HOST: begin
        dec_o.host = 1'b1;
        if (value_i[2:0] == 3'b100) begin
          dec_o.push  = 1'b1;
          dec_o.sound = SND_LONG;
        end else if (value_i[1:0] == 2'b10) begin
          dec_o.push  = 1'b1;
          dec_o.sound = SND_SHORT;
        end
      end
      CMD_KEY: begin
        dec_o.push  = click_on_i;
        dec_o.sound = SND_CLICK;
      end
      CMD_POP: begin
        dec_o.pop = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/kcsq_ring.sv]
// ----------------------------------------------------------------------------
// kcsq_ring
// Sound queue: ring memory with head and fill count; drops oldest when full.
// ----------------------------------------------------------------------------
module kcsq_ring import kcsq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ring_req_t         req_i,
  output logic [FILL_W-1:0] fill_o,
  output logic              popped_valid_o,
  output logic [1:0]        popped_sound_o
);

  logic [1:0]        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  head_q, head_d, head_inc, tail;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [SUM_W-1:0]  sum;
  logic              pv_q, pv_d;
  logic [1:0]        rd_q;
  logic              full, empty, do_push, do_pop;

  assign full    = fill_q == FILL_W'(QUEUE_DEPTH);
  assign empty   = fill_q == '0;
  assign do_push = req_i.step && req_i.push;
  assign do_pop  = req_i.step && req_i.pop && !empty;

  assign head_inc = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

  // tail = (head + fill) mod depth, sum stays below twice the depth
  assign sum  = SUM_W'(head_q) + SUM_W'(fill_q);
  assign tail = (sum >= SUM_W'(QUEUE_DEPTH)) ? PTR_W'(sum - SUM_W'(QUEUE_DEPTH))
                                             : PTR_W'(sum);

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (do_push) begin
      if (full) head_d = head_inc;
      else      fill_d = fill_q + 1'b1;
    end else if (do_pop) begin
      head_d = head_inc;
      fill_d = fill_q - 1'b1;
    end
  end

  assign pv_d = req_i.step ? do_pop : pv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      pv_q   <= 1'b0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
      pv_q   <= pv_d;
    end
  end

  // full queue: new entry lands on the oldest slot
  always_ff @(posedge clk_i) begin
    if (do_push) mem[full ? head_q : tail] <= req_i.sound;
  end

  always_ff @(posedge clk_i) begin
    if (do_pop) rd_q <= mem[head_q];
  end

  assign fill_o         = fill_q;
  assign popped_valid_o = pv_q;
  assign popped_sound_o = pv_q ? rd_q : SND_NONE;

endmodule

[rtl/keyboard_command_sound_queue_unit.sv]
// ----------------------------------------------------------------------------
// keyboard_command_sound_queue_unit
// Keyboard controller: host commands, LEDs, key modes and a sound queue.
// ----------------------------------------------------------------------------
//  channel   | dir | transaction payload
//  ----------+-----+-----------------------------------------------------------
//  item_i    | in  | cmd (host write / keypress / pop), value (host byte)
//  result_o  | out | LEDs, modes, popped sound, latest sound, counters, fill
//
//  One item per cycle sustained while result_o is ready; each item passes the
//  input register, then the state/result registers, queue memory read alongside.
//  The result register is the state itself: it only changes when an item moves
//  out of the input register, so a stalled result holds while one more item
//  waits in the input register.
//  Reset is asynchronous; the queue memory is not cleared (only filled slots
//  are ever read), so the unit takes items right after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keyboard_command_sound_queue_unit import kcsq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  kcsq_cmd_if.sink   item_i,
  kcsq_res_if.source result_o
);

  // Input register
  logic       in_valid_q;
  logic [1:0] in_cmd_q;
  logic [7:0] in_value_q;
  logic       in_take;

  // Step: item leaves input register and lands in the state/result registers
  logic       step;
  logic       out_valid_q;

  // Controller state (doubles as the result register)
  logic [7:0]  led_q;
  logic        click_q, rpt_q, qwz_q;
  logic [7:0]  cmd_byte_q;
  logic [31:0] cmd_cnt_q, snd_cnt_q;
  snd_e        recent_q;

  dec_t              dec;
  ring_req_t         ring_req;
  logic [FILL_W-1:0] fill;
  logic              popped_valid;
  logic [1:0]        popped_sound;

  assign step         = in_valid_q && (!out_valid_q || result_o.ready);
  assign in_take      = item_i.valid && item_i.ready;
  assign item_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take)   in_valid_q <= 1'b1;
      else if (step) in_valid_q <= 1'b0;
      if (step)                 out_valid_q <= 1'b1;
      else if (result_o.ready)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q   <= item_i.cmd;
      in_value_q <= item_i.value;
    end
  end

  kcsq_decode u_decode (
    .cmd_i      (in_cmd_q),
    .value_i    (in_value_q),
    .click_on_i (click_q),
    .dec_o      (dec)
  );

  assign ring_req.step  = step;
  assign ring_req.push  = dec.push;
  assign ring_req.pop   = dec.pop;
  assign ring_req.sound = dec.sound;

  kcsq_ring u_ring (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (ring_req),
    .fill_o         (fill),
    .popped_valid_o (popped_valid),
    .popped_sound_o (popped_sound)
  );

  // State update, one item per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q      <= '0;
      click_q    <= 1'b1;
      rpt_q      <= 1'b1;
      qwz_q      <= 1'b0;
      cmd_byte_q <= '0;
      cmd_cnt_q  <= '0;
      snd_cnt_q  <= '0;
      recent_q   <= SND_NONE;
    end else if (step) begin
      if (dec.host) begin
        led_q      <= dec.led;
        cmd_byte_q <= in_value_q;
        cmd_cnt_q  <= cmd_cnt_q + 32'd1;
        if (dec.mode_upd) begin
          click_q <= dec.click;
          rpt_q   <= dec.rpt;
          qwz_q   <= dec.qwertz;
        end
      end
      if (dec.push) begin
        recent_q  <= dec.sound;
        snd_cnt_q <= snd_cnt_q + 32'd1;
      end
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.led_pattern    = led_q;
  assign result_o.click_on       = click_q;
  assign result_o.autorepeat_on  = rpt_q;
  assign result_o.qwertz_on      = qwz_q;
  assign result_o.popped_valid   = popped_valid;
  assign result_o.popped_sound   = popped_sound;
  assign result_o.latest_sound   = recent_q;
  assign result_o.sound_total    = snd_cnt_q;
  assign result_o.pending_total  = pending_t'(fill);
  assign result_o.latest_command = cmd_byte_q;
  assign result_o.command_total  = cmd_cnt_q;

  // ---- assertions ----
  `ASSERT_ALWAYS(a_fill_bound, fill <= FILL_W'(QUEUE_DEPTH), "queue fill above depth")
  `ASSERT_RST(a_snd_cnt_step, (snd_cnt_q != $past(snd_cnt_q)) |-> ($past(step) && snd_cnt_q == $past(snd_cnt_q) + 32'd1), "sound count moved without a step")
  `ASSERT_RST(a_pop_fill, (step && dec.pop && fill != '0) |=> (popped_valid && fill == $past(fill) - 1'b1), "pop did not drain queue")

endmodule

[verif/tb_keyboard_command_sound_queue_unit.sv]
// ----------------------------------------------------------------------------
// tb_keyboard_command_sound_queue_unit
// Self-checking bench for the keyboard command / sound queue unit: a cycle-free
// copy of the keyboard state tracks every accepted transaction, and each status
// transaction from the unit is compared field by field against it.
// ----------------------------------------------------------------------------
module tb_keyboard_command_sound_queue_unit import kcsq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Run length and stall shaping
  localparam int CYCLE_LIMIT  = 200000;  // generous: ~1600 items, worst stalls
  localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
  localparam int SEGMENTS     = 12;      // random part, in segments
  localparam int SEGMENT_LEN  = 100;
  localparam int DRAIN_CYCLES = 8;       // pipeline drain plus margin

  // Status as seen after one transaction
  typedef struct packed {
    logic [7:0]  led;
    logic        click;
    logic        rpt;
    logic        qwertz;
    logic        popped_valid;
    snd_e        popped;
    snd_e        latest;
    logic [31:0] sound_cnt;
    logic [7:0]  fill;
    logic [7:0]  last_cmd;
    logic [31:0] cmd_cnt;
  } status_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  kcsq_cmd_if item_if ();
  kcsq_res_if res_if ();

  keyboard_command_sound_queue_unit uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if)
  );

  always #10 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Keyboard state mirror (reset values of the unit)
  // --------------------------------------------------------------------------
  logic [7:0]  kb_led      = 8'h00;
  logic        kb_click    = 1'b1;
  logic        kb_rpt      = 1'b1;
  logic        kb_qwertz   = 1'b0;
  logic [7:0]  kb_last_cmd = 8'h00;
  logic [31:0] kb_cmd_cnt  = 32'd0;
  logic [31:0] kb_snd_cnt  = 32'd0;
  snd_e        kb_recent   = SND_NONE;
  snd_e        kb_ring[$];           // oldest sound at index 0

  status_t status_q[$];              // statuses owed by the unit, oldest first

  // Bookkeeping
  int mismatches       = 0;
  int statuses_checked = 0;
  int items_issued     = 0;
  int cmd_seen[4]      = '{default: 0};
  int sounds_dropped   = 0;
  int pops_with_sound  = 0;
  int pops_on_empty    = 0;
  int mode_updates     = 0;
  int peak_fill        = 0;
  int cycle_cnt        = 0;
  bit hold_req         = 1'b0;       // asks the receiver for a long hold-off

  // Queue a sound; a full ring loses its oldest entry
  function automatic void push_sound(snd_e s);
    kb_recent = s;
    kb_snd_cnt++;
    if (kb_ring.size() >= QUEUE_DEPTH) begin
      kb_ring.delete(0);
      sounds_dropped++;
    end
    kb_ring.insert(kb_ring.size(), s);
    if (kb_ring.size() > peak_fill) peak_fill = kb_ring.size();
  endfunction

  // Apply one accepted transaction and return the status it leaves behind
  function automatic status_t run_keyboard_item(cmd_e c, logic [7:0] v);
    status_t    st;
    logic [7:0] pat;
    st = '0;
    case (c)
      CMD_HOST: begin
        kb_last_cmd = v;
        kb_cmd_cnt++;
        // LED byte: -2 for low bits 00, as is for 01, -1 for 10/11
        case (v[1:0])
          2'b00:   pat = v - 8'd2;
          2'b01:   pat = v;
          default: pat = v - 8'd1;
        endcase
        kb_led = pat;
        if ((v & MODE_MASK) == MODE_MASK) begin
          kb_click  = ~v[3];
          kb_rpt    = ~v[5];
          kb_qwertz = v[7];
          mode_updates++;
        end
        // long beep wins over short beep
        if (v[2:0] == 3'b100) begin
          push_sound(SND_LONG);
        end else if (v[1:0] == 2'b10) begin
          push_sound(SND_SHORT);
        end
      end
      CMD_KEY: begin
        if (kb_click) push_sound(SND_CLICK);
      end
      CMD_POP: begin
        if (kb_ring.size() > 0) begin
          st.popped_valid = 1'b1;
          st.popped       = kb_ring[0];
          kb_ring.delete(0);
          pops_with_sound++;
        end else begin
          pops_on_empty++;
        end
      end
      default: ;  // unused selector leaves everything alone
    endcase
    st.led       = kb_led;
    st.click     = kb_click;
    st.rpt       = kb_rpt;
    st.qwertz    = kb_qwertz;
    st.latest    = kb_recent;
    st.sound_cnt = kb_snd_cnt;
    st.fill      = 8'(kb_ring.size());
    st.last_cmd  = kb_last_cmd;
    st.cmd_cnt   = kb_cmd_cnt;
    return st;
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Called right after a rising edge. Valid stays high on return so that a
  // following call in the same step does not toggle it.
  task automatic issue_item(cmd_e c, logic [7:0] v);
    item_if.valid <= 1'b1;
    item_if.cmd   <= c;
    item_if.value <= v;
    do @(posedge clk_i); while (item_if.ready !== 1'b1);
    status_q.insert(status_q.size(), run_keyboard_item(c, v));
    items_issued++;
    cmd_seen[c]++;
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      item_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Host bytes: a quarter of them carry the full mode mask so modes move often
  function automatic logic [7:0] random_host_byte();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) v = v | MODE_MASK;
    return v;
  endfunction

  // One random transaction; pop_pct sets how hard the queue is drained
  task automatic issue_random(int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < pop_pct) begin
      issue_item(CMD_POP, 8'($urandom_range(0, 255)));
    end else if (r < pop_pct + 4) begin
      issue_item(CMD_NOP, 8'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 1) == 0) begin
      issue_item(CMD_HOST, random_host_byte());
    end else begin
      issue_item(CMD_KEY, 8'($urandom_range(0, 255)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: the cycle counter sets when the stall pattern changes; a hold request
  // drops ready for a long fixed stretch so the unit backs up into its input.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int style;
    res_if.ready <= 1'b0;
    style = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      if (cycle_cnt % 256 == 0) style = $urandom_range(0, 3);
      case (style)
        0:       res_if.ready <= 1'b1;                          // no stalls
        1:       res_if.ready <= ($urandom_range(0, 1) == 0);
        2:       res_if.ready <= ($urandom_range(0, 9) != 0);
        default: res_if.ready <= ($urandom_range(0, 4) == 0);   // mostly stalled
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Status check: every status transaction against the oldest owed status
  // --------------------------------------------------------------------------
  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : status_check
    status_t want;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (status_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: status transaction expected none, actual led %0h cmd_total %0h",
                 $time, res_if.led_pattern, res_if.command_total);
      end else begin
        want = status_q[0];
        status_q.delete(0);
        check_field("led_pattern",    want.led,          res_if.led_pattern);
        check_field("click_on",       want.click,        res_if.click_on);
        check_field("autorepeat_on",  want.rpt,          res_if.autorepeat_on);
        check_field("qwertz_on",      want.qwertz,       res_if.qwertz_on);
        check_field("popped_valid",   want.popped_valid, res_if.popped_valid);
        check_field("popped_sound",   want.popped,       res_if.popped_sound);
        check_field("latest_sound",   want.latest,       res_if.latest_sound);
        check_field("sound_total",    want.sound_cnt,    res_if.sound_total);
        check_field("pending_total",  want.fill,         res_if.pending_total);
        check_field("latest_command", want.last_cmd,     res_if.latest_command);
        check_field("command_total",  want.cmd_cnt,      res_if.command_total);
        statuses_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d statuses owed", cycle_cnt, status_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // LED decode corners, mode mask hits and misses, both beep kinds
  task automatic test_host_commands();
    issue_item(CMD_HOST, 8'h00);  // LED wraps to FE, no beep
    issue_item(CMD_HOST, 8'hFF);  // full mask: click/repeat off, qwertz on
    issue_item(CMD_HOST, 8'h01);  // low bits 01: LED is the byte itself
    issue_item(CMD_HOST, 8'h02);  // short beep
    issue_item(CMD_HOST, 8'h03);
    issue_item(CMD_HOST, 8'h04);  // long beep
    issue_item(CMD_HOST, 8'h57);  // mask exactly: all defaults back
    issue_item(CMD_HOST, 8'h56);  // one mask bit short, no mode change
    issue_item(CMD_HOST, 8'h5F);  // click off
    issue_item(CMD_HOST, 8'h77);  // autorepeat off, click back on
    issue_item(CMD_HOST, 8'hD7);  // qwertz on
    issue_item(CMD_HOST, 8'hAA);
    issue_item(CMD_HOST, 8'h57);
  endtask

  // Key clicks only while clicks are enabled
  task automatic test_key_clicks();
    issue_item(CMD_KEY, 8'hFF);
    issue_item(CMD_HOST, 8'h5F);  // clicks off
    issue_item(CMD_KEY, 8'h00);   // no sound
    issue_item(CMD_HOST, 8'h57);  // clicks on
    issue_item(CMD_KEY, 8'h5A);
  endtask

  // Pops until and past empty; unused selector before and after
  task automatic test_pops_and_nop();
    issue_item(CMD_NOP, 8'hFF);
    repeat (7) issue_item(CMD_POP, 8'h00);
    issue_item(CMD_NOP, 8'h00);
  endtask

  // Overfill the ring so oldest sounds fall out, then drain past empty
  task automatic test_queue_overflow();
    issue_item(CMD_HOST, 8'h57);
    for (int i = 0; i < QUEUE_DEPTH + 12; i++) begin
      case (i % 3)
        0:       issue_item(CMD_KEY, 8'($urandom_range(0, 255)));
        1:       issue_item(CMD_HOST, 8'h04 | (8'($urandom_range(0, 31)) << 3));
        default: issue_item(CMD_HOST, 8'h02 | (8'($urandom_range(0, 63)) << 2));
      endcase
    end
    repeat (QUEUE_DEPTH + 2) issue_item(CMD_POP, 8'($urandom_range(0, 255)));
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (40) issue_random(20);
    while (hold_req) @(posedge clk_i);
  endtask

  // Random traffic in bursts; segments lean toward filling or draining
  task automatic test_random_traffic();
    int pop_pct;
    int burst_left;
    bit gapless;
    burst_left = $urandom_range(1, 24);
    for (int s = 0; s < SEGMENTS; s++) begin
      case ($urandom_range(0, 2))
        0:       pop_pct = 5;    // fill toward overflow
        1:       pop_pct = 30;
        default: pop_pct = 65;   // drain, pops on empty
      endcase
      gapless = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < SEGMENT_LEN; i++) begin
        issue_random(pop_pct);
        if (--burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (!gapless && $urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        <= 1'b0;
    item_if.valid <= 1'b0;
    item_if.cmd   <= CMD_NOP;
    item_if.value <= 8'h00;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_host_commands();
    test_key_clicks();
    test_pops_and_nop();
    test_queue_overflow();
    test_backpressure();
    test_random_traffic();
    idle_sender(1);

    while (status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d transactions (host %0d, key %0d, pop %0d, unused %0d), %0d statuses",
             items_issued, cmd_seen[CMD_HOST], cmd_seen[CMD_KEY], cmd_seen[CMD_POP],
             cmd_seen[CMD_NOP], statuses_checked);
    $display("Mode updates %0d, sounds dropped %0d, peak fill %0d, empty pops %0d",
             mode_updates, sounds_dropped, peak_fill, pops_on_empty);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
